// ----- hdl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, token kind codes, keyword table and byte helpers
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned DEF_MAX_KEYWORD_LENGTH = 11;
  localparam int unsigned DEF_LINE_WIDTH         = 20;
  localparam int unsigned DEF_COLUMN_WIDTH       = 16;
  localparam int unsigned DEF_LENGTH_WIDTH       = 16;

  localparam int unsigned MAX_RES  = 4;
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW    = 3;
  localparam int unsigned NKEYS    = 66;
  localparam int unsigned KW_CHARS = 11;

  localparam logic [6:0] K_FLOAT   = 7'd66;
  localparam logic [6:0] K_INT     = 7'd67;
  localparam logic [6:0] K_IDENT   = 7'd68;
  localparam logic [6:0] K_STRING  = 7'd69;
  localparam logic [6:0] K_CHAR    = 7'd70;
  localparam logic [6:0] K_SLDOT   = 7'd77;
  localparam logic [6:0] K_SLASH   = 7'd78;
  localparam logic [6:0] K_DOTOP   = 7'd89;
  localparam logic [6:0] K_STRICT  = 7'd93;
  localparam logic [6:0] K_EQ      = 7'd94;
  localparam logic [6:0] K_UNKNOWN = 7'd116;
  localparam logic [6:0] K_END     = 7'd117;
  localparam logic [6:0] K_NONE    = 7'd0;

  typedef enum logic [4:0] {
    M_IDLE, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_NUM, M_NUMDOT, M_FRAC,
    M_WORD, M_STR, M_STRESC, M_COPEN, M_CESC, M_CCLOSE, M_OP1, M_EQ2
  } mode_e;

  typedef struct packed {
    logic space;
    logic digit;
    logic start;
    logic word;
  } cls_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] char_byte;
    logic       end_of_source;
    cls_t       cls;
  } item_t;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [NKEYS] = '{
    "if", "elseif", "else", "end", "for", "in", "while", "do", "switch", "case",
    "default", "return", "continue", "break", "class", "interface", "template",
    "public", "protected", "private", "constructor", "destructor", "namespace",
    "using", "include", "exclude", "define", "ifdef", "endif", "auto", "void",
    "type", "arguments", "parallel", "true", "false", "null", "nan", "inf", "pi",
    "region", "endregion", "suite", "test", "assert", "int4", "int8", "int16",
    "int32", "int64", "single", "double", "bool", "char", "string", "vector",
    "matrix", "layer", "collection", "point2", "point3", "point4", "time", "file",
    "rtti", "method"
  };

  localparam int unsigned KW_LEN [NKEYS] = '{
    2, 6, 4, 3, 3, 2, 5, 2, 6, 4, 7,
    6, 8, 5, 5, 9, 8, 6,
    9, 7, 11, 10, 9, 5,
    7, 7, 6, 5, 5, 4, 4, 4,
    9, 8, 4, 5, 4, 3, 3, 2, 6,
    9, 5, 4, 6,
    4, 4, 5, 5, 5, 6, 6, 4, 4,
    6, 6, 6, 5, 10, 6, 6, 6,
    4, 4, 4, 6
  };

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    logic alpha;
    alpha   = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    c.space = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    c.digit = (b >= "0" && b <= "9");
    c.start = alpha || (b == "_");
    c.word  = c.start || c.digit;
    return c;
  endfunction

  function automatic logic has_second(input logic [7:0] b);
    return b == "+" || b == "-" || b == "*" || b == "%" || b == "^" || b == "." ||
           b == "=" || b == "<" || b == ">" || b == "!" || b == "&" || b == "|";
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] k;
    case (b)
      "+": k = 7'd72;   "-": k = 7'd74;   "*": k = 7'd76;   "/": k = 7'd78;
      "\\": k = 7'd79;  "%": k = 7'd82;   "^": k = 7'd84;   ".": k = 7'd89;
      ",": k = 7'd90;   ";": k = 7'd91;   ":": k = 7'd92;   "=": k = 7'd73;
      "<": k = 7'd97;   ">": k = 7'd100;  "!": k = 7'd103;  "&": k = 7'd105;
      "|": k = 7'd107;  "?": k = 7'd108;  "(": k = 7'd110;  ")": k = 7'd111;
      "[": k = 7'd112;  "]": k = 7'd113;  "{": k = 7'd114;  "}": k = 7'd115;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // K_NONE when the pair is no operator
  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] k;
    k = K_NONE;
    case (a)
      "+": if (b == ".") k = 7'd71;
      "-": if (b == ">") k = 7'd73;
      "*": if (b == ".") k = 7'd75;
      "%": begin
        if (b == "%") k = 7'd80;
        else if (b == ".") k = 7'd81;
      end
      "^": if (b == ".") k = 7'd83;
      ".": begin
        if (b == "=") k = 7'd81;
        else if (b == "<") k = 7'd85;
        else if (b == ">") k = 7'd86;
        else if (b == "&") k = 7'd87;
        else if (b == "|") k = 7'd88;
      end
      "<": begin
        if (b == "=") k = 7'd95;
        else if (b == "<") k = 7'd96;
      end
      ">": begin
        if (b == "=") k = 7'd98;
        else if (b == ">") k = 7'd99;
      end
      "!": begin
        if (b == "=") k = 7'd101;
        else if (b == "!") k = 7'd102;
      end
      "&": if (b == "&") k = 7'd104;
      "|": if (b == "|") k = 7'd106;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/stt_front.sv -----
// ----------------------------------------------------------------------------
// stt_front
// accepts input words, classifies the byte and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          has_byte_i,
  input  wire logic [7:0]    char_byte_i,
  input  wire logic          end_of_source_i,
  output logic               item_valid_o,
  input  wire logic          item_ready_i,
  output stt_pkg::item_t     item_o
);

  stt_pkg::item_t mem_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rp_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].has_byte      <= has_byte_i;
      mem_q[wp_q].char_byte     <= char_byte_i;
      mem_q[wp_q].end_of_source <= end_of_source_i;
      mem_q[wp_q].cls           <= stt_pkg::classify(char_byte_i);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stt_scanner.sv -----
// ----------------------------------------------------------------------------
// stt_scanner
// scan state machine: one word per cycle while the output queue has room, up to four tokens per word
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scanner #(
  parameter int unsigned MAX_KEYWORD_LENGTH = stt_pkg::DEF_MAX_KEYWORD_LENGTH,
  parameter int unsigned LINE_WIDTH         = stt_pkg::DEF_LINE_WIDTH,
  parameter int unsigned COLUMN_WIDTH       = stt_pkg::DEF_COLUMN_WIDTH,
  parameter int unsigned LENGTH_WIDTH       = stt_pkg::DEF_LENGTH_WIDTH,
  parameter int unsigned TOK_W = 7 + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  output logic                       item_ready_o,
  input  wire stt_pkg::item_t        item_i,
  input  wire logic                  room_i,
  output logic [2:0]                 wr_n_o,
  output logic [4*TOK_W-1:0]         wr_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_KEYWORD_LENGTH);

  typedef logic [LINE_WIDTH-1:0]   line_t;
  typedef logic [COLUMN_WIDTH-1:0] col_t;
  typedef logic [LENGTH_WIDTH-1:0] len_t;

  typedef struct packed {
    logic [6:0] kind;
    line_t      line;
    col_t       col;
    len_t       len;
    logic [7:0] val;
    logic       last;
  } tok_t;

  typedef struct packed {
    stt_pkg::mode_e mode;
    logic [7:0]     pend0;
    logic [7:0]     pend1;
    line_t          tl;
    col_t           tc;
    len_t           len;
    logic [7:0]     lit;
    line_t          hl;
    col_t           hc;
  } st_t;

  typedef struct packed {
    st_t              s;
    logic             done;
    logic             ev;
    tok_t             t;
    logic             we;
    logic [IDX_W-1:0] widx;
  } cres_t;

  typedef struct packed {
    logic ev1;
    tok_t t1;
    logic ev2;
    tok_t t2;
  } fres_t;

  typedef logic [MAX_KEYWORD_LENGTH-1:0][7:0] wview_t;

  st_t        st_q, st_d;
  line_t      line_q, line_d;
  col_t       col_q, col_d;
  logic       ended_q, ended_d;
  logic [7:0] wbuf_q [MAX_KEYWORD_LENGTH];
  logic       wb_we;
  logic [IDX_W-1:0] wb_idx;
  logic [7:0] wb_byte;
  logic       take;
  logic [6:0] kw_now;
  wview_t     view_now, view_new;

  function automatic len_t grow(input len_t v);
    return (v == '1) ? v : v + len_t'(1);
  endfunction

  function automatic tok_t mk(input logic [6:0] k, input line_t l, input col_t c,
                              input len_t n, input logic [7:0] v);
    tok_t t;
    t.kind = k;
    t.line = l;
    t.col  = c;
    t.len  = n;
    t.val  = v;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [6:0] kw_lookup(input wview_t v, input len_t n);
    logic [6:0] k;
    logic       found;
    logic       m;
    k     = stt_pkg::K_IDENT;
    found = 1'b0;
    if (n <= len_t'(MAX_KEYWORD_LENGTH)) begin
      for (int i = 0; i < stt_pkg::NKEYS; i++) begin
        m = (n == len_t'(stt_pkg::KW_LEN[i]));
        for (int j = 0; j < stt_pkg::KW_CHARS; j++) begin
          if (j < stt_pkg::KW_LEN[i]) begin
            m = m && (v[j] == stt_pkg::KW_TEXT[i][8*(stt_pkg::KW_LEN[i]-1-j) +: 8]);
          end
        end
        if (m && !found) begin
          found = 1'b1;
          k     = 7'(i);
        end
      end
    end
    return k;
  endfunction

  function automatic cres_t consume(input st_t s, input logic [7:0] b,
                                    input stt_pkg::cls_t c, input logic [6:0] kw,
                                    input line_t al, input col_t ac);
    cres_t      r;
    logic [6:0] pk;
    r      = '0;
    r.s    = s;
    r.done = 1'b1;
    pk     = stt_pkg::pair_kind(s.pend0, b);
    case (s.mode)
      stt_pkg::M_IDLE: begin
        if (!c.space) begin
          r.s.tl  = al;
          r.s.tc  = ac;
          r.s.len = '0;
          r.s.lit = '0;
          if (c.digit) begin
            r.s.mode = stt_pkg::M_NUM;
            r.s.len  = len_t'(1);
          end else if (c.start) begin
            r.s.mode = stt_pkg::M_WORD;
            r.s.len  = len_t'(1);
            r.we     = 1'b1;
            r.widx   = '0;
          end else if (b == "\"") begin
            r.s.mode = stt_pkg::M_STR;
          end else if (b == "'") begin
            r.s.mode = stt_pkg::M_COPEN;
          end else if (b == "/") begin
            r.s.mode = stt_pkg::M_SLASH;
          end else if (stt_pkg::has_second(b)) begin
            r.s.pend0 = b;
            r.s.mode  = stt_pkg::M_OP1;
          end else begin
            r.ev = 1'b1;
            r.t  = mk(stt_pkg::single_kind(b), al, ac, len_t'(1), 8'd0);
          end
        end
      end
      stt_pkg::M_SLASH: begin
        if (b == "/") begin
          r.s.mode = stt_pkg::M_LCOM;
        end else if (b == "*") begin
          r.s.mode = stt_pkg::M_BCOM;
        end else begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          if (b == ".") begin
            r.t = mk(stt_pkg::K_SLDOT, s.tl, s.tc, len_t'(2), 8'd0);
          end else begin
            r.t    = mk(stt_pkg::K_SLASH, s.tl, s.tc, len_t'(1), 8'd0);
            r.done = 1'b0;
          end
        end
      end
      stt_pkg::M_LCOM: begin
        if (b == 8'd10) r.s.mode = stt_pkg::M_IDLE;
      end
      stt_pkg::M_BCOM: begin
        if (b == "*") r.s.mode = stt_pkg::M_BSTAR;
      end
      stt_pkg::M_BSTAR: begin
        if (b == "/") r.s.mode = stt_pkg::M_IDLE;
        else if (b != "*") r.s.mode = stt_pkg::M_BCOM;
      end
      stt_pkg::M_NUM: begin
        if (c.digit) begin
          r.s.len = grow(s.len);
        end else if (b == ".") begin
          r.s.pend1 = b;
          r.s.hl    = al;
          r.s.hc    = ac;
          r.s.mode  = stt_pkg::M_NUMDOT;
        end else begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          r.t      = mk(stt_pkg::K_INT, s.tl, s.tc, s.len, 8'd0);
          r.done   = 1'b0;
        end
      end
      stt_pkg::M_NUMDOT: begin
        if (c.digit) begin
          r.s.len  = grow(grow(s.len));
          r.s.mode = stt_pkg::M_FRAC;
        end else begin
          // the held dot becomes a pending operator at its own position
          r.ev      = 1'b1;
          r.t       = mk(stt_pkg::K_INT, s.tl, s.tc, s.len, 8'd0);
          r.s.mode  = stt_pkg::M_OP1;
          r.s.pend0 = s.pend1;
          r.s.tl    = s.hl;
          r.s.tc    = s.hc;
          r.s.len   = '0;
          r.s.lit   = '0;
          r.done    = 1'b0;
        end
      end
      stt_pkg::M_FRAC: begin
        if (c.digit) begin
          r.s.len = grow(s.len);
        end else begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          r.t      = mk(stt_pkg::K_FLOAT, s.tl, s.tc, s.len, 8'd0);
          r.done   = 1'b0;
        end
      end
      stt_pkg::M_WORD: begin
        if (c.word) begin
          if (s.len < len_t'(MAX_KEYWORD_LENGTH)) begin
            r.we   = 1'b1;
            r.widx = s.len[IDX_W-1:0];
          end
          r.s.len = grow(s.len);
        end else begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          r.t      = mk(kw, s.tl, s.tc, s.len, 8'd0);
          r.done   = 1'b0;
        end
      end
      stt_pkg::M_STR: begin
        if (b == "\"") begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          r.t      = mk(stt_pkg::K_STRING, s.tl, s.tc, s.len, 8'd0);
        end else if (b == "\\") begin
          r.s.mode = stt_pkg::M_STRESC;
        end else begin
          r.s.len = grow(s.len);
        end
      end
      stt_pkg::M_STRESC: begin
        r.s.len  = grow(s.len);
        r.s.mode = stt_pkg::M_STR;
      end
      stt_pkg::M_COPEN: begin
        if (b == "\\") begin
          r.s.mode = stt_pkg::M_CESC;
        end else if (b == "'") begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          r.t      = mk(stt_pkg::K_CHAR, s.tl, s.tc, s.len, s.lit);
        end else begin
          r.s.lit  = b;
          r.s.len  = len_t'(1);
          r.s.mode = stt_pkg::M_CCLOSE;
        end
      end
      stt_pkg::M_CESC: begin
        if (b == "n") r.s.lit = 8'd10;
        else if (b == "t") r.s.lit = 8'd9;
        else if (b == "r") r.s.lit = 8'd13;
        else r.s.lit = b;
        r.s.len  = len_t'(1);
        r.s.mode = stt_pkg::M_CCLOSE;
      end
      stt_pkg::M_CCLOSE: begin
        r.s.mode = stt_pkg::M_IDLE;
        r.ev     = 1'b1;
        r.t      = mk(stt_pkg::K_CHAR, s.tl, s.tc, s.len, s.lit);
        r.done   = (b == "'");
      end
      stt_pkg::M_OP1: begin
        if (s.pend0 == "=" && b == "=") begin
          r.s.mode = stt_pkg::M_EQ2;
        end else begin
          r.s.mode = stt_pkg::M_IDLE;
          r.ev     = 1'b1;
          if (pk != stt_pkg::K_NONE) begin
            r.t = mk(pk, s.tl, s.tc, len_t'(2), 8'd0);
          end else begin
            r.t    = mk(stt_pkg::single_kind(s.pend0), s.tl, s.tc, len_t'(1), 8'd0);
            r.done = 1'b0;
          end
        end
      end
      stt_pkg::M_EQ2: begin
        r.s.mode = stt_pkg::M_IDLE;
        r.ev     = 1'b1;
        if (b == "=") begin
          r.t = mk(stt_pkg::K_STRICT, s.tl, s.tc, len_t'(3), 8'd0);
        end else begin
          r.t    = mk(stt_pkg::K_EQ, s.tl, s.tc, len_t'(2), 8'd0);
          r.done = 1'b0;
        end
      end
      default: begin
        r.s.mode = stt_pkg::M_IDLE;
        r.done   = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic fres_t finish(input st_t s, input logic [6:0] kw);
    fres_t f;
    f = '0;
    case (s.mode)
      stt_pkg::M_SLASH: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_SLASH, s.tl, s.tc, len_t'(1), 8'd0);
      end
      stt_pkg::M_NUM: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_INT, s.tl, s.tc, s.len, 8'd0);
      end
      stt_pkg::M_NUMDOT: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_INT, s.tl, s.tc, s.len, 8'd0);
        f.ev2 = 1'b1;
        f.t2  = mk(stt_pkg::K_DOTOP, s.hl, s.hc, len_t'(1), 8'd0);
      end
      stt_pkg::M_FRAC: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_FLOAT, s.tl, s.tc, s.len, 8'd0);
      end
      stt_pkg::M_WORD: begin
        f.ev1 = 1'b1;
        f.t1  = mk(kw, s.tl, s.tc, s.len, 8'd0);
      end
      stt_pkg::M_STR: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_STRING, s.tl, s.tc, s.len, 8'd0);
      end
      stt_pkg::M_STRESC: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_STRING, s.tl, s.tc, grow(s.len), 8'd0);
      end
      stt_pkg::M_COPEN, stt_pkg::M_CCLOSE: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_CHAR, s.tl, s.tc, s.len, s.lit);
      end
      stt_pkg::M_CESC: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_CHAR, s.tl, s.tc, len_t'(1), 8'd92);
      end
      stt_pkg::M_OP1: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::single_kind(s.pend0), s.tl, s.tc, len_t'(1), 8'd0);
      end
      stt_pkg::M_EQ2: begin
        f.ev1 = 1'b1;
        f.t1  = mk(stt_pkg::K_EQ, s.tl, s.tc, len_t'(2), 8'd0);
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  assign item_ready_o = room_i;
  assign take         = item_valid_i && room_i;

  always_comb begin
    for (int j = 0; j < MAX_KEYWORD_LENGTH; j++) begin
      view_now[j] = wbuf_q[j];
    end
    kw_now = kw_lookup(view_now, st_q.len);
  end

  always_comb begin
    st_t        s;
    cres_t      cr;
    fres_t      fr;
    tok_t       tk [stt_pkg::MAX_RES];
    logic [2:0] n;
    logic       act;
    logic       fin;
    line_t      al;
    col_t       ac;
    logic [6:0] kw_fin;

    s       = st_q;
    line_d  = line_q;
    col_d   = col_q;
    ended_d = ended_q;
    n       = 3'd0;
    fin     = 1'b0;
    act     = 1'b0;
    al      = line_q;
    ac      = col_q;
    wb_we   = 1'b0;
    wb_idx  = '0;
    wb_byte = item_i.char_byte;
    cr      = '0;
    fr      = '0;
    for (int i = 0; i < stt_pkg::MAX_RES; i++) tk[i] = '0;

    if (take && !ended_q && item_i.has_byte) begin
      if (item_i.char_byte == 8'd0) begin
        fin = 1'b1;
      end else begin
        if (item_i.char_byte == 8'd10) begin
          line_d = (line_q == '1) ? line_q : line_q + line_t'(1);
          col_d  = col_t'(1);
        end else begin
          col_d = (col_q == '1) ? col_q : col_q + col_t'(1);
        end
        act = 1'b1;
        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
          if (act) begin
            cr = consume(s, item_i.char_byte, item_i.cls, kw_now, line_q, col_q);
            s  = cr.s;
            if (cr.ev && n < 3'd4) begin
              tk[n[1:0]] = cr.t;
              n          = n + 3'd1;
            end
            if (cr.we) begin
              wb_we  = 1'b1;
              wb_idx = cr.widx;
            end
            act = !cr.done;
          end
        end
      end
    end

    if (take && !ended_q && !fin && item_i.end_of_source) begin
      fin = 1'b1;
      al  = line_d;
      ac  = col_d;
    end

    for (int j = 0; j < MAX_KEYWORD_LENGTH; j++) begin
      view_new[j] = (wb_we && wb_idx == IDX_W'(j)) ? wb_byte : wbuf_q[j];
    end
    kw_fin = kw_lookup(view_new, s.len);

    if (fin) begin
      fr = finish(s, kw_fin);
      if (fr.ev1 && n < 3'd4) begin
        tk[n[1:0]] = fr.t1;
        n          = n + 3'd1;
      end
      if (fr.ev2 && n < 3'd4) begin
        tk[n[1:0]] = fr.t2;
        n          = n + 3'd1;
      end
      if (n < 3'd4) begin
        tk[n[1:0]] = mk(stt_pkg::K_END, al, ac, '0, 8'd0);
        n          = n + 3'd1;
      end
      s.mode  = stt_pkg::M_IDLE;
      ended_d = 1'b1;
    end

    if (n != 3'd0) tk[2'(n - 3'd1)].last = 1'b1;

    st_d   = s;
    wr_n_o = n;
    for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
      wr_data_o[i*TOK_W +: TOK_W] = tk[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '{mode: stt_pkg::M_IDLE, pend0: 8'd0, pend1: 8'd0,
                   tl: line_t'(1), tc: col_t'(1), len: len_t'(0), lit: 8'd0,
                   hl: line_t'(1), hc: col_t'(1)};
      line_q  <= line_t'(1);
      col_q   <= col_t'(1);
      ended_q <= 1'b0;
    end else if (take) begin
      st_q    <= st_d;
      line_q  <= line_d;
      col_q   <= col_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && wb_we) begin
      wbuf_q[wb_idx] <= wb_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stt_out_queue.sv -----
// ----------------------------------------------------------------------------
// stt_out_queue
// token queue: up to four words written per cycle, one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module stt_out_queue #(
  parameter int unsigned TOK_W = 68
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [2:0]           wr_n_i,
  input  wire logic [4*TOK_W-1:0]   wr_data_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [TOK_W-1:0]          out_data_o
);

  localparam int unsigned AW = stt_pkg::OQ_AW;

  logic [TOK_W-1:0] mem_q [stt_pkg::OQ_DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign room_o      = (cnt_q <= (AW+1)'(stt_pkg::OQ_DEPTH - stt_pkg::MAX_RES));
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wp_d  = wp_q + AW'(wr_n_i);
    rp_d  = pop ? rp_q + AW'(1) : rp_q;
    cnt_d = cnt_q + (AW+1)'(wr_n_i) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
      if (3'(i) < wr_n_i) begin
        mem_q[wp_q + AW'(i)] <= wr_data_i[i*TOK_W +: TOK_W];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming tokenizer: one source byte per input word, tokens out
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o with has_byte_i, char_byte_i and
// end_of_source_i. Output channel: out_valid_o/out_ready_i, one token per word,
// last_of_run_o marking the final token caused by one input word.
// An input word goes through a two-entry front queue and then the scanner,
// which writes zero to four tokens for it at once into an eight-entry output
// queue. A token is offered once the word that completes it has passed the
// front queue register, the scanner and the output queue register. Sustained
// rate is one input word per cycle while the output queue has room; the
// scanner waits while fewer than four output entries are free, so runs of
// tokens drain through the read port, one per cycle while out_ready_i is high.
// A receiver that stalls fills the output queue and then the front queue,
// after which in_ready_o drops. Reset empties both queues, returns the scanner
// to its idle state and sets line and column to one. After the end token
// further input words are taken and give no tokens until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned MAX_KEYWORD_LENGTH = stt_pkg::DEF_MAX_KEYWORD_LENGTH,
  parameter int unsigned LINE_WIDTH         = stt_pkg::DEF_LINE_WIDTH,
  parameter int unsigned COLUMN_WIDTH       = stt_pkg::DEF_COLUMN_WIDTH,
  parameter int unsigned LENGTH_WIDTH       = stt_pkg::DEF_LENGTH_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    has_byte_i,
  input  wire logic [7:0]              char_byte_i,
  input  wire logic                    end_of_source_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [6:0]                   token_kind_o,
  output logic [LINE_WIDTH-1:0]        start_line_o,
  output logic [COLUMN_WIDTH-1:0]      start_column_o,
  output logic [LENGTH_WIDTH-1:0]      text_length_o,
  output logic [7:0]                   char_value_o,
  output logic                         last_of_run_o
);

  localparam int unsigned TOK_W = 7 + LINE_WIDTH + COLUMN_WIDTH + LENGTH_WIDTH + 9;
  localparam int unsigned LEN_LO  = 9;
  localparam int unsigned COL_LO  = LEN_LO + LENGTH_WIDTH;
  localparam int unsigned LINE_LO = COL_LO + COLUMN_WIDTH;
  localparam int unsigned KIND_LO = LINE_LO + LINE_WIDTH;

  stt_pkg::item_t       item;
  logic                 item_valid;
  logic                 item_ready;
  logic                 room;
  logic [2:0]           wr_n;
  logic [4*TOK_W-1:0]   wr_data;
  logic [TOK_W-1:0]     out_data;

  stt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .has_byte_i      (has_byte_i),
    .char_byte_i     (char_byte_i),
    .end_of_source_i (end_of_source_i),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready),
    .item_o          (item)
  );

  stt_scanner #(
    .MAX_KEYWORD_LENGTH (MAX_KEYWORD_LENGTH),
    .LINE_WIDTH         (LINE_WIDTH),
    .COLUMN_WIDTH       (COLUMN_WIDTH),
    .LENGTH_WIDTH       (LENGTH_WIDTH),
    .TOK_W              (TOK_W)
  ) u_scanner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .room_i       (room),
    .wr_n_o       (wr_n),
    .wr_data_o    (wr_data)
  );

  stt_out_queue #(
    .TOK_W (TOK_W)
  ) u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_n_i      (wr_n),
    .wr_data_i   (wr_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign last_of_run_o  = out_data[0];
  assign char_value_o   = out_data[8:1];
  assign text_length_o  = out_data[LEN_LO +: LENGTH_WIDTH];
  assign start_column_o = out_data[COL_LO +: COLUMN_WIDTH];
  assign start_line_o   = out_data[LINE_LO +: LINE_WIDTH];
  assign token_kind_o   = out_data[KIND_LO +: 7];

endmodule

`default_nettype wire
